@@ hw/rtl/rpr_pkg.sv @@
// Shared types, constants and the frequency table function of the rotary position rotator.
// Depends on nothing; every other file of the block takes its names from here.
package rpr_pkg;

    localparam int unsigned HEAD_DIM_DEF = 64;

    localparam int unsigned POS_W   = 10;
    localparam int unsigned PAIR_W  = 5;
    localparam int unsigned DATA_W  = 18;
    localparam int unsigned FREQ_W  = 32;
    localparam int unsigned PHASE_W = 32;
    localparam int unsigned TRIG_W  = 16;
    localparam int unsigned IN_W    = 88;
    localparam int unsigned OUT_W   = 72;

    localparam logic [63:0] LOG2_BASE_Q40 = 64'd18262492834822;
    localparam logic [63:0] LN2_Q31       = 64'd1488522236;
    localparam logic [63:0] INV2PI_Q32    = 64'd683565276;
    localparam logic [63:0] ONE_Q31       = 64'd2147483648;
    localparam logic [30:0] HALFPI_Q30    = 31'd1686629713;
    localparam logic [31:0] ONE_Q30       = 32'd1073741824;

    localparam int unsigned SERIES_STEPS = 7;
    localparam int unsigned SIN_STEPS    = 6;
    localparam int unsigned SIN_DIV [SERIES_STEPS] = '{6, 20, 42, 72, 110, 156, 2};
    localparam int unsigned COS_DIV [SERIES_STEPS] = '{2, 12, 30, 56, 90, 132, 182};
    localparam int unsigned STEP_STG = 4;

    localparam int unsigned PHASE_STG = 2;
    localparam int unsigned TRIG_STG  = 2 + STEP_STG * SERIES_STEPS + 1;
    localparam int unsigned ROT_STG   = 3;
    localparam int unsigned PAY_STG   = PHASE_STG + TRIG_STG;
    localparam int unsigned PIPE_STG  = PAY_STG + ROT_STG;

    typedef logic [PIPE_STG-1:0] t_stg;

    typedef enum logic [1:0] {
        QUAD_I   = 2'd0,
        QUAD_II  = 2'd1,
        QUAD_III = 2'd2,
        QUAD_IV  = 2'd3
    } t_quad;

    // Sums are two's complement values kept in plain vectors.
    typedef struct packed {
        t_quad       quad;
        logic [31:0] a2;
        logic [31:0] s_term;
        logic [32:0] s_sum;
        logic [31:0] c_term;
        logic [32:0] c_sum;
    } t_ser;

    typedef struct packed {
        logic [DATA_W-1:0] q_lo;
        logic [DATA_W-1:0] q_hi;
        logic [DATA_W-1:0] k_lo;
        logic [DATA_W-1:0] k_hi;
    } t_qk;

    // Turns per position, 32 fraction bits, from the Q40 exponent of the period.
    function automatic logic [31:0] freq_from_t(input logic [63:0] t_exp);
        logic [63:0]        f_y;
        logic [63:0]        f_term;
        logic signed [63:0] f_sum;
        logic [63:0]        f_rnd;
        int unsigned        f_n;
        int unsigned        f_k;
        f_n    = int'(t_exp[63:40]);
        f_y    = (64'(t_exp[39:9]) * LN2_Q31) >> 31;
        f_term = ONE_Q31;
        f_sum  = $signed(ONE_Q31);
        for (f_k = 1; f_k <= 12; f_k++) begin
            f_term = ((f_term * f_y) >> 31) / 64'(f_k);
            if (f_k % 2 == 1) begin
                f_sum = f_sum - $signed(f_term);
            end else begin
                f_sum = f_sum + $signed(f_term);
            end
        end
        if (f_sum < 0) begin
            f_sum = '0;
        end
        f_rnd = ($unsigned(f_sum) * INV2PI_Q32 + (64'd1 << (30 + f_n))) >> (31 + f_n);
        return f_rnd[31:0];
    endfunction

endpackage

@@ hw/rtl/rpr_phase.sv @@
// Frequency table lookup and phase multiply, two register stages.
// Depends on rpr_pkg for widths and the table function.
module rpr_phase #(
    parameter int unsigned HEAD_DIM = rpr_pkg::HEAD_DIM_DEF
) (
    input  logic                              i_clk,
    input  logic [rpr_pkg::PHASE_STG-1:0]     i_en,
    input  logic [rpr_pkg::POS_W-1:0]         i_pos,
    input  logic [rpr_pkg::PAIR_W-1:0]        i_pair,
    output logic [rpr_pkg::PHASE_W-1:0]       o_phase
);

    localparam int unsigned HALF_DIM = HEAD_DIM / 2;
    localparam int unsigned ROM_N    = 2 ** rpr_pkg::PAIR_W;
    localparam int unsigned PROD_W   = rpr_pkg::POS_W + rpr_pkg::FREQ_W;

    logic [rpr_pkg::FREQ_W-1:0]  w_rom [ROM_N];
    logic [rpr_pkg::FREQ_W-1:0]  r_freq;
    logic [rpr_pkg::POS_W-1:0]   r_pos;
    logic [rpr_pkg::PHASE_W-1:0] r_phase;
    logic [PROD_W-1:0]           w_prod;

    // Pair indexes beyond the head wrap around half the head dimension.
    for (genvar j = 0; j < ROM_N; j++) begin : g_rom
        localparam logic [63:0] T_EXP =
            (64'(2 * (j % HALF_DIM)) * rpr_pkg::LOG2_BASE_Q40) / 64'(HEAD_DIM);
        localparam logic [31:0] FREQ = rpr_pkg::freq_from_t(T_EXP);
        assign w_rom[j] = FREQ[rpr_pkg::FREQ_W-1:0];
    end

    assign w_prod = PROD_W'(r_pos) * PROD_W'(r_freq);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_freq <= w_rom[i_pair];
            r_pos  <= i_pos;
        end
        if (i_en[1]) begin
            r_phase <= w_prod[rpr_pkg::PHASE_W-1:0];
        end
    end

    assign o_phase = r_phase;

endmodule

@@ hw/rtl/rpr_step.sv @@
// One term of the sine and cosine series: multiply, reciprocal divide, correct, accumulate.
// Four register stages; depends on rpr_pkg for the series record.
module rpr_step #(
    parameter int unsigned S_DIV = 6,
    parameter int unsigned C_DIV = 2,
    parameter bit          S_ON  = 1'b1,
    parameter bit          NEG   = 1'b1
) (
    input  logic                            i_clk,
    input  logic [rpr_pkg::STEP_STG-1:0]    i_en,
    input  rpr_pkg::t_ser                   i_ser,
    output rpr_pkg::t_ser                   o_ser
);

    localparam logic [31:0] S_M = 32'((64'd1 << 32) / 64'(S_DIV));
    localparam logic [31:0] C_M = 32'((64'd1 << 32) / 64'(C_DIV));

    rpr_pkg::t_ser r0_ser, r1_ser, r2_ser, r3_ser;
    rpr_pkg::t_ser n2_ser, n3_ser;
    logic [31:0]   r0_sx, r0_cx, r1_sx, r1_cx, r1_sq, r1_cq;
    logic [63:0]   w_sp, w_cp, w_sr, w_cr;
    logic [39:0]   w_srem, w_crem;

    assign w_sp = 64'(i_ser.s_term) * 64'(i_ser.a2);
    assign w_cp = 64'(i_ser.c_term) * 64'(i_ser.a2);
    assign w_sr = 64'(r0_sx) * 64'(S_M);
    assign w_cr = 64'(r0_cx) * 64'(C_M);

    // The reciprocal quotient is at most one short; the remainder check fixes it.
    assign w_srem = 40'(r1_sx) - 40'(r1_sq) * 40'(S_DIV);
    assign w_crem = 40'(r1_cx) - 40'(r1_cq) * 40'(C_DIV);

    always_comb begin
        n2_ser        = r1_ser;
        n2_ser.c_term = r1_cq + 32'(w_crem >= 40'(C_DIV));
        if (S_ON) begin
            n2_ser.s_term = r1_sq + 32'(w_srem >= 40'(S_DIV));
        end
    end

    always_comb begin
        n3_ser = r2_ser;
        if (NEG) begin
            n3_ser.c_sum = r2_ser.c_sum - 33'(r2_ser.c_term);
        end else begin
            n3_ser.c_sum = r2_ser.c_sum + 33'(r2_ser.c_term);
        end
        if (S_ON) begin
            if (NEG) begin
                n3_ser.s_sum = r2_ser.s_sum - 33'(r2_ser.s_term);
            end else begin
                n3_ser.s_sum = r2_ser.s_sum + 33'(r2_ser.s_term);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r0_ser <= i_ser;
            r0_sx  <= w_sp[61:30];
            r0_cx  <= w_cp[61:30];
        end
        if (i_en[1]) begin
            r1_ser <= r0_ser;
            r1_sx  <= r0_sx;
            r1_cx  <= r0_cx;
            r1_sq  <= w_sr[63:32];
            r1_cq  <= w_cr[63:32];
        end
        if (i_en[2]) begin
            r2_ser <= n2_ser;
        end
        if (i_en[3]) begin
            r3_ser <= n3_ser;
        end
    end

    assign o_ser = r3_ser;

endmodule

@@ hw/rtl/rpr_trig.sv @@
// Cosine and sine in Q1.15 of a 32-bit turn fraction through a pipelined Taylor series.
// Depends on rpr_pkg and instantiates rpr_step once per series term.
module rpr_trig (
    input  logic                                i_clk,
    input  logic [rpr_pkg::TRIG_STG-1:0]        i_en,
    input  logic [rpr_pkg::PHASE_W-1:0]         i_phase,
    output logic signed [rpr_pkg::TRIG_W-1:0]   o_cos,
    output logic signed [rpr_pkg::TRIG_W-1:0]   o_sin
);

    localparam int unsigned LAST = rpr_pkg::TRIG_STG - 1;

    logic [30:0]                      r_a;
    rpr_pkg::t_quad                   r_quad;
    rpr_pkg::t_ser                    r_ser0;
    rpr_pkg::t_ser                    w_ser [rpr_pkg::SERIES_STEPS+1];
    logic [60:0]                      w_ap;
    logic [61:0]                      w_a2p;
    logic signed [rpr_pkg::TRIG_W-1:0] w_s0, w_c0, n_cos, n_sin;
    logic signed [rpr_pkg::TRIG_W-1:0] r_cos, r_sin;
    rpr_pkg::t_ser                    w_fin;

    function automatic logic signed [15:0] to_q15(input logic [32:0] v);
        logic signed [32:0] c;
        logic [16:0]        rnd;
        c = $signed(v);
        if (c < 0) begin
            c = '0;
        end else if (c > $signed({1'b0, rpr_pkg::ONE_Q30})) begin
            c = $signed({1'b0, rpr_pkg::ONE_Q30});
        end
        rnd = 17'(($unsigned(c) + 33'd16384) >> 15);
        if (rnd > 17'd32767) begin
            rnd = 17'd32767;
        end
        return $signed(rnd[15:0]);
    endfunction

    assign w_ap  = 61'(i_phase[29:0]) * 61'(rpr_pkg::HALFPI_Q30);
    assign w_a2p = 62'(r_a) * 62'(r_a);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_a    <= w_ap[60:30];
            r_quad <= rpr_pkg::t_quad'(i_phase[31:30]);
        end
        if (i_en[1]) begin
            r_ser0.quad   <= r_quad;
            r_ser0.a2     <= w_a2p[61:30];
            r_ser0.s_term <= 32'(r_a);
            r_ser0.s_sum  <= 33'(r_a);
            r_ser0.c_term <= rpr_pkg::ONE_Q30;
            r_ser0.c_sum  <= 33'(rpr_pkg::ONE_Q30);
        end
    end

    assign w_ser[0] = r_ser0;

    for (genvar k = 0; k < rpr_pkg::SERIES_STEPS; k++) begin : g_step
        rpr_step #(
            .S_DIV (rpr_pkg::SIN_DIV[k]),
            .C_DIV (rpr_pkg::COS_DIV[k]),
            .S_ON  (k < rpr_pkg::SIN_STEPS),
            .NEG   ((k % 2) == 0)
        ) u_step (
            .i_clk (i_clk),
            .i_en  (i_en[2 + rpr_pkg::STEP_STG * k +: rpr_pkg::STEP_STG]),
            .i_ser (w_ser[k]),
            .o_ser (w_ser[k+1])
        );
    end

    assign w_fin = w_ser[rpr_pkg::SERIES_STEPS];
    assign w_s0  = to_q15(w_fin.s_sum);
    assign w_c0  = to_q15(w_fin.c_sum);

    always_comb begin
        case (w_fin.quad)
            rpr_pkg::QUAD_I: begin
                n_cos = w_c0;
                n_sin = w_s0;
            end
            rpr_pkg::QUAD_II: begin
                n_cos = -w_s0;
                n_sin = w_c0;
            end
            rpr_pkg::QUAD_III: begin
                n_cos = -w_c0;
                n_sin = -w_s0;
            end
            default: begin
                n_cos = w_s0;
                n_sin = -w_c0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[LAST]) begin
            r_cos <= n_cos;
            r_sin <= n_sin;
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

@@ hw/rtl/rpr_rotate.sv @@
// Rotation of the query and key pairs by cosine and sine, with rounding and saturation.
// Three register stages; depends on rpr_pkg for the pair record.
module rpr_rotate (
    input  logic                                i_clk,
    input  logic [rpr_pkg::ROT_STG-1:0]         i_en,
    input  logic signed [rpr_pkg::TRIG_W-1:0]   i_cos,
    input  logic signed [rpr_pkg::TRIG_W-1:0]   i_sin,
    input  rpr_pkg::t_qk                        i_qk,
    output rpr_pkg::t_qk                        o_qk
);

    localparam int unsigned P_W = rpr_pkg::DATA_W + rpr_pkg::TRIG_W;
    localparam int unsigned S_W = P_W + 1;

    logic signed [P_W-1:0] r_p [8];
    logic signed [S_W-1:0] r_s [4];
    rpr_pkg::t_qk          r_qk;

    // Round to nearest with ties away from zero, then clamp to the data range.
    function automatic logic [17:0] rnd_sat(input logic signed [34:0] acc);
        logic signed [34:0] v;
        if (acc < 0) begin
            v = (acc + 35'sd16383) >>> 15;
        end else begin
            v = (acc + 35'sd16384) >>> 15;
        end
        if (v > 35'sd131071) begin
            return 18'h1FFFF;
        end else if (v < -35'sd131072) begin
            return 18'h20000;
        end
        return v[17:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_p[0] <= $signed(i_qk.q_lo) * i_cos;
            r_p[1] <= $signed(i_qk.q_hi) * i_sin;
            r_p[2] <= $signed(i_qk.q_hi) * i_cos;
            r_p[3] <= $signed(i_qk.q_lo) * i_sin;
            r_p[4] <= $signed(i_qk.k_lo) * i_cos;
            r_p[5] <= $signed(i_qk.k_hi) * i_sin;
            r_p[6] <= $signed(i_qk.k_hi) * i_cos;
            r_p[7] <= $signed(i_qk.k_lo) * i_sin;
        end
        if (i_en[1]) begin
            r_s[0] <= S_W'(r_p[0]) + S_W'(r_p[1]);
            r_s[1] <= S_W'(r_p[2]) - S_W'(r_p[3]);
            r_s[2] <= S_W'(r_p[4]) + S_W'(r_p[5]);
            r_s[3] <= S_W'(r_p[6]) - S_W'(r_p[7]);
        end
        if (i_en[2]) begin
            r_qk.q_lo <= rnd_sat(r_s[0]);
            r_qk.q_hi <= rnd_sat(r_s[1]);
            r_qk.k_lo <= rnd_sat(r_s[2]);
            r_qk.k_hi <= rnd_sat(r_s[3]);
        end
    end

    assign o_qk = r_qk;

endmodule

@@ hw/rtl/rotary_position_rotator.sv @@
// Top level of the rotary position rotator: stream ports, stage valid bits, payload delay line.
// Depends on rpr_pkg and instantiates rpr_phase, rpr_trig and rpr_rotate.
//
//   Channel  Dir  Width  Contents
//   s_axis   in   88     position, pair index, query and key pairs
//   m_axis   out  72     rotated query and key pairs
//
// One transfer per cycle is sustained while m_axis_tready is high.
// Most of the pipeline stages belong to the seven-term Taylor series, four stages per term.
// Reset clears only the stage valid bits; the data registers need none.
// A stage holds while it and every stage after it are full and m_axis_tready is low,
// so empty stages close up and s_axis keeps taking transfers during an output stall until every stage is full.
module rotary_position_rotator #(
    parameter int unsigned HEAD_DIM = rpr_pkg::HEAD_DIM_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // position, pair_index, query_low, query_high, key_low, key_high, zero pad
    input  logic [rpr_pkg::IN_W-1:0]      s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // query_low_rot, query_high_rot, key_low_rot, key_high_rot
    output logic [rpr_pkg::OUT_W-1:0]     m_axis_tdata
);

    localparam int unsigned N = rpr_pkg::PIPE_STG;

    rpr_pkg::t_stg                       r_vld, n_vld, w_en;
    rpr_pkg::t_qk                        w_in_qk, w_out_qk;
    rpr_pkg::t_qk                        r_pay [rpr_pkg::PAY_STG];
    logic [rpr_pkg::PHASE_W-1:0]         w_phase;
    logic signed [rpr_pkg::TRIG_W-1:0]   w_cos, w_sin;

    assign w_in_qk.q_lo = s_axis_tdata[32:15];
    assign w_in_qk.q_hi = s_axis_tdata[50:33];
    assign w_in_qk.k_lo = s_axis_tdata[68:51];
    assign w_in_qk.k_hi = s_axis_tdata[86:69];

    always_comb begin
        for (int k = 0; k < N; k++) begin
            w_en[k] = m_axis_tready ||
                      !(&(r_vld | ((rpr_pkg::t_stg'(1) << k) - rpr_pkg::t_stg'(1))));
        end
    end

    assign n_vld = (w_en & {r_vld[N-2:0], s_axis_tvalid}) | (~w_en & r_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_pay[0] <= w_in_qk;
        end
        for (int k = 1; k < rpr_pkg::PAY_STG; k++) begin
            if (w_en[k]) begin
                r_pay[k] <= r_pay[k-1];
            end
        end
    end

    rpr_phase #(
        .HEAD_DIM (HEAD_DIM)
    ) u_phase (
        .i_clk   (i_clk),
        .i_en    (w_en[0 +: rpr_pkg::PHASE_STG]),
        .i_pos   (s_axis_tdata[9:0]),
        .i_pair  (s_axis_tdata[14:10]),
        .o_phase (w_phase)
    );

    rpr_trig u_trig (
        .i_clk   (i_clk),
        .i_en    (w_en[rpr_pkg::PHASE_STG +: rpr_pkg::TRIG_STG]),
        .i_phase (w_phase),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    rpr_rotate u_rotate (
        .i_clk (i_clk),
        .i_en  (w_en[rpr_pkg::PAY_STG +: rpr_pkg::ROT_STG]),
        .i_cos (w_cos),
        .i_sin (w_sin),
        .i_qk  (r_pay[rpr_pkg::PAY_STG-1]),
        .o_qk  (w_out_qk)
    );

    assign s_axis_tready = w_en[0];
    assign m_axis_tvalid = r_vld[N-1];
    assign m_axis_tdata  = {w_out_qk.k_hi, w_out_qk.k_lo, w_out_qk.q_hi, w_out_qk.q_lo};

`ifndef SYNTHESIS
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ($countones(r_vld) == $past($countones(r_vld))
                  + int'($past(s_axis_tvalid && s_axis_tready))
                  - int'($past(m_axis_tvalid && m_axis_tready))))
        else $error("Pipeline occupancy does not match the transfers.");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("Stage valid bits not cleared by reset.");

    a_trig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[rpr_pkg::PAY_STG-1] |-> (w_cos != 16'sh8000) && (w_sin != 16'sh8000))
        else $error("Cosine or sine outside the Q1.15 range.");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for rotary_position_rotator: drives query and key pairs, predicts
// each rotated result with its own fixed-point model and compares every output transfer.
// Depends on rpr_pkg and the rotary_position_rotator RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ROPE_HEAD_DIM = 64;
    localparam int unsigned ROPE_HALF_DIM = ROPE_HEAD_DIM / 2;
    localparam int unsigned RANDOM_PAIRS  = 1550;
    localparam int unsigned DRAIN_EVERY   = 500;
    localparam int unsigned SETTLE_CYCLES = 60;
    localparam int unsigned CYCLE_LIMIT   = 600000;

    localparam bit [63:0] EXP_LOG2_Q40 = 64'd18262492834822;
    localparam bit [63:0] LN2_Q31_K    = 64'd1488522236;
    localparam bit [63:0] TURN_Q32_K   = 64'd683565276;
    localparam bit [63:0] HALFPI_Q30_K = 64'd1686629713;
    localparam bit [63:0] UNIT_Q30     = 64'd1 << 30;
    localparam bit [63:0] UNIT_Q31     = 64'd1 << 31;
    localparam longint    SAMPLE_MAX   = 131071;
    localparam longint    SAMPLE_MIN   = -131072;

    typedef struct {
        logic [9:0]         pos;
        logic [4:0]         pair;
        logic signed [17:0] q_lo;
        logic signed [17:0] q_hi;
        logic signed [17:0] k_lo;
        logic signed [17:0] k_hi;
        bit                 drain;
    } t_pair_in;

    typedef struct {
        logic signed [17:0] q_lo_rot;
        logic signed [17:0] q_hi_rot;
        logic signed [17:0] k_lo_rot;
        logic signed [17:0] k_hi_rot;
    } t_pair_out;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [rpr_pkg::IN_W-1:0]   s_axis_tdata = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [rpr_pkg::OUT_W-1:0]  m_axis_tdata;

    t_pair_in    pending_pairs[$];
    t_pair_out   expected_rot[$];
    t_pair_out   rot_got;
    t_pair_out   rot_want;
    int unsigned pairs_sent = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned saturated_fields = 0;
    int unsigned drain_pauses = 0;
    int unsigned cycle_count = 0;
    int unsigned tx_gap = 0;
    int unsigned tx_window = 0;
    bit          tx_calm = 1'b0;
    bit          tx_valid_nxt;
    int unsigned rx_stall = 0;
    int unsigned rx_window = 0;
    bit          rx_calm = 1'b0;

    rotary_position_rotator #(
        .HEAD_DIM(ROPE_HEAD_DIM)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    // Turns per position in Q32 for pair idx, from the base-2 exponent of its period.
    function automatic bit [63:0] pair_turn_rate(input int unsigned idx);
        bit [63:0]   t_exp;
        bit [63:0]   frac;
        bit [63:0]   y;
        bit [63:0]   term;
        longint      sum;
        int unsigned n;
        int unsigned k;
        t_exp = (64'(2 * idx) * EXP_LOG2_Q40) / 64'(ROPE_HEAD_DIM);
        n     = int'(t_exp >> 40);
        frac  = t_exp & ((64'd1 << 40) - 64'd1);
        y     = ((frac >> 9) * LN2_Q31_K) >> 31;
        term  = UNIT_Q31;
        sum   = longint'(UNIT_Q31);
        for (k = 1; k <= 12; k++) begin
            term = ((term * y) >> 31) / 64'(k);
            if (k % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        return (64'(sum) * TURN_Q32_K + (64'd1 << (30 + n))) >> (31 + n);
    endfunction

    function automatic longint q30_unit_to_q15(input longint v);
        longint r;
        r = v;
        if (r < 0) begin
            r = 0;
        end
        if (r > longint'(UNIT_Q30)) begin
            r = longint'(UNIT_Q30);
        end
        r = (r + 16384) >>> 15;
        return (r > 32767) ? 32767 : r;
    endfunction

    function automatic logic signed [17:0] round_saturate(input longint acc);
        longint v;
        if (acc >= 0) begin
            v = (acc + 16384) >>> 15;
        end else begin
            v = -((-acc + 16384) >>> 15);
        end
        if (v > SAMPLE_MAX) begin
            v = SAMPLE_MAX;
        end
        if (v < SAMPLE_MIN) begin
            v = SAMPLE_MIN;
        end
        return 18'(v);
    endfunction

    function automatic t_pair_out rotate_pair(input t_pair_in p);
        t_pair_out      res;
        bit [31:0]      phase;
        rpr_pkg::t_quad quad;
        bit [63:0]      a;
        bit [63:0]      a2;
        bit [63:0]      term;
        longint         ssum;
        longint         csum;
        longint         s0;
        longint         c0;
        longint         cs;
        longint         sn;
        int unsigned    k;
        phase = 32'(64'(p.pos) * pair_turn_rate(int'(p.pair) % ROPE_HALF_DIM));
        quad  = rpr_pkg::t_quad'(phase[31:30]);
        a     = (64'(phase[29:0]) * HALFPI_Q30_K) >> 30;
        a2    = (a * a) >> 30;
        term  = a;
        ssum  = longint'(a);
        for (k = 1; k <= 6; k++) begin
            term = ((term * a2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                ssum = ssum - longint'(term);
            end else begin
                ssum = ssum + longint'(term);
            end
        end
        term = UNIT_Q30;
        csum = longint'(UNIT_Q30);
        for (k = 1; k <= 7; k++) begin
            term = ((term * a2) >> 30) / 64'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) begin
                csum = csum - longint'(term);
            end else begin
                csum = csum + longint'(term);
            end
        end
        s0 = q30_unit_to_q15(ssum);
        c0 = q30_unit_to_q15(csum);
        case (quad)
            rpr_pkg::QUAD_I: begin
                cs = c0;
                sn = s0;
            end
            rpr_pkg::QUAD_II: begin
                cs = -s0;
                sn = c0;
            end
            rpr_pkg::QUAD_III: begin
                cs = -c0;
                sn = -s0;
            end
            default: begin
                cs = s0;
                sn = -c0;
            end
        endcase
        res.q_lo_rot = round_saturate(longint'(p.q_lo) * cs + longint'(p.q_hi) * sn);
        res.q_hi_rot = round_saturate(longint'(p.q_hi) * cs - longint'(p.q_lo) * sn);
        res.k_lo_rot = round_saturate(longint'(p.k_lo) * cs + longint'(p.k_hi) * sn);
        res.k_hi_rot = round_saturate(longint'(p.k_hi) * cs - longint'(p.k_lo) * sn);
        return res;
    endfunction

    function automatic logic [rpr_pkg::IN_W-1:0] pack_pair(input t_pair_in p);
        return {1'b0, p.k_hi, p.k_lo, p.q_hi, p.q_lo, p.pair, p.pos};
    endfunction

    function automatic int unsigned draw_gap(input bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [17:0] draw_sample();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 18'($urandom);
        end else if (r < 85) begin
            case ($urandom_range(0, 4))
                0: return 18'(SAMPLE_MIN);
                1: return 18'(SAMPLE_MAX);
                2: return 18'sd0;
                3: return -18'sd1;
                default: return 18'sd1;
            endcase
        end
        return 18'($signed($urandom_range(0, 8191)) - 4096);
    endfunction

    function automatic t_pair_in make_pair(input logic [9:0] pos, input logic [4:0] pair,
                                           input longint q_lo, input longint q_hi,
                                           input longint k_lo, input longint k_hi,
                                           input bit drain);
        t_pair_in p;
        p.pos   = pos;
        p.pair  = pair;
        p.q_lo  = 18'(q_lo);
        p.q_hi  = 18'(q_hi);
        p.k_lo  = 18'(k_lo);
        p.k_hi  = 18'(k_hi);
        p.drain = drain;
        return p;
    endfunction

    task automatic check_field(input string name, input logic signed [17:0] want,
                               input logic signed [17:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
        if (got === 18'(SAMPLE_MAX) || got === 18'(SAMPLE_MIN)) begin
            saturated_fields++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            tx_valid_nxt = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                expected_rot.push_back(rotate_pair(pending_pairs.pop_front()));
                pairs_sent++;
                tx_valid_nxt = 1'b0;
                tx_gap = draw_gap(tx_calm);
            end
            if (tx_window == 0) begin
                tx_window = $urandom_range(50, 300);
                tx_calm = ($urandom_range(0, 3) == 0);
            end else begin
                tx_window--;
            end
            if (!tx_valid_nxt && pending_pairs.size() != 0) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                end else if (!pending_pairs[0].drain || pairs_sent == results_seen) begin
                    tx_valid_nxt = 1'b1;
                    s_axis_tdata <= pack_pair(pending_pairs[0]);
                end
            end
            s_axis_tvalid <= tx_valid_nxt;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                rot_got.q_lo_rot = m_axis_tdata[17:0];
                rot_got.q_hi_rot = m_axis_tdata[35:18];
                rot_got.k_lo_rot = m_axis_tdata[53:36];
                rot_got.k_hi_rot = m_axis_tdata[71:54];
                if (expected_rot.size() == 0) begin
                    $error("Output transfer with no pending expectation: tdata %h", m_axis_tdata);
                    mismatches++;
                end else begin
                    rot_want = expected_rot.pop_front();
                    check_field("query_low_rot", rot_want.q_lo_rot, rot_got.q_lo_rot);
                    check_field("query_high_rot", rot_want.q_hi_rot, rot_got.q_hi_rot);
                    check_field("key_low_rot", rot_want.k_lo_rot, rot_got.k_lo_rot);
                    check_field("key_high_rot", rot_want.k_hi_rot, rot_got.k_hi_rot);
                end
                results_seen <= results_seen + 1;
            end
            if (rx_window == 0) begin
                rx_window = $urandom_range(50, 300);
                rx_calm = ($urandom_range(0, 3) == 0);
            end else begin
                rx_window--;
            end
            if (rx_stall != 0) begin
                rx_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                rx_stall = draw_gap(rx_calm);
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_rot.size());
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin
        int unsigned n;
        // Position zero gives no rotation, so cosine sits just below one.
        pending_pairs.push_back(make_pair(10'd0, 5'd0, 4096, -4096, 131071, -131072, 1'b0));
        pending_pairs.push_back(make_pair(10'd0, 5'd31, 131071, 131071, -131072, -131072, 1'b0));
        pending_pairs.push_back(make_pair(10'd1023, 5'd0, 131071, 0, 0, 131071, 1'b0));
        pending_pairs.push_back(make_pair(10'd1023, 5'd31, -131072, -1, -1, -131072, 1'b0));
        pending_pairs.push_back(make_pair(10'd1, 5'd0, 131071, 131071, -131072, 131071, 1'b0));
        pending_pairs.push_back(make_pair(10'd2, 5'd0, 131071, 131071, -131072, -131072, 1'b0));
        pending_pairs.push_back(make_pair(10'd3, 5'd0, 4096, 0, 0, 4096, 1'b0));
        pending_pairs.push_back(make_pair(10'd5, 5'd0, -131072, 131071, 131071, -131072, 1'b0));
        pending_pairs.push_back(make_pair(10'd512, 5'd1, 1, -1, 1, -1, 1'b0));
        pending_pairs.push_back(make_pair(10'd100, 5'd16, 0, 0, 0, 0, 1'b0));
        pending_pairs.push_back(make_pair(10'd777, 5'd15, 131071, -131072, 65536, -65536, 1'b0));
        pending_pairs.push_back(make_pair(10'd341, 5'd1, -131072, -131072, 131071, 131071, 1'b0));
        pending_pairs.push_back(make_pair(10'd682, 5'd2, 12345, -54321, -98765, 23456, 1'b0));
        pending_pairs.push_back(make_pair(10'd1023, 5'd30, 131071, 131071, 131071, 131071, 1'b0));
        pending_pairs.push_back(make_pair(10'd7, 5'd8, -1, -1, -1, -1, 1'b0));
        pending_pairs.push_back(make_pair(10'd400, 5'd4, 100000, -100000, -7, 7, 1'b0));
        pending_pairs.push_back(make_pair(10'd1, 5'd31, -131072, 0, 0, -131072, 1'b0));
        pending_pairs.push_back(make_pair(10'd999, 5'd3, 131071, -1, -131072, 1, 1'b0));
        for (n = 0; n < RANDOM_PAIRS; n++) begin
            pending_pairs.push_back(make_pair(
                ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1) * 1023)
                                            : 10'($urandom),
                5'($urandom_range(0, 31)),
                draw_sample(), draw_sample(), draw_sample(), draw_sample(),
                (n % DRAIN_EVERY == 0)));
            if (n % DRAIN_EVERY == 0) begin
                drain_pauses++;
            end
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        while (pending_pairs.size() != 0 || expected_rot.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("Streamed %0d pair transfers and checked %0d rotated results in %0d cycles.",
                 pairs_sent, results_seen, cycle_count);
        $display("%0d output fields saturated; the sender drained the pipeline %0d times.",
                 saturated_fields, drain_pauses);
        if (mismatches == 0 && expected_rot.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

@@ rotary_position_rotator.f @@
hw/rtl/rpr_pkg.sv
hw/rtl/rpr_phase.sv
hw/rtl/rpr_step.sv
hw/rtl/rpr_trig.sv
hw/rtl/rpr_rotate.sv
hw/rtl/rotary_position_rotator.sv
tb/sv/tb_top.sv
